// ===== src/mwfe_pkg.sv =====
// package: constants, types and helpers shared by the frame extractor modules
package mwfe_pkg;

	localparam int COUNT_BITS = 20;
	localparam int MAXCFG_BITS = 20;
	localparam int LEN_BITS = 32;

	localparam logic [63:0] MAGIC_WORD = 64'h0201_0403_0605_0807;
	localparam logic [MAXCFG_BITS-1:0] MAX_RESET = 20'd65536;
	localparam logic [MAXCFG_BITS-1:0] MIN_FRAME = 20'd16;

	// frame positions of the byte after the magic word and of the last length byte
	localparam logic [COUNT_BITS-1:0] POS_AFTER_MAGIC = COUNT_BITS'(8);
	localparam logic [COUNT_BITS-1:0] POS_LEN_LAST = COUNT_BITS'(15);

	typedef struct packed {
		logic       valid;
		logic       burst;
		logic [7:0] data;
		logic       last;
		logic       err;
	} res_t;

	function automatic logic [7:0] magic_byte(input logic [2:0] idx);
		logic [2:0] lane;
		lane = 3'd7 - idx;
		return MAGIC_WORD[{lane, 3'b000} +: 8];
	endfunction

endpackage

// ===== src/mwfe_if.sv =====
// handshake interfaces for the received byte and frame byte channels
interface byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface frame_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       frame_first;
	logic       frame_last;
	logic       length_error;

	modport source (output valid, output frame_byte, output frame_first,
		output frame_last, output length_error, input ready);
	modport sink (input valid, input frame_byte, input frame_first,
		input frame_last, input length_error, output ready);
endinterface

// ===== src/magic_word_frame_extractor.sv =====
// top level: magic word frame extractor
//
//   channel | dir | handshake     | payload
//   rx      | in  | valid/ready   | rx_byte[7:0]
//   frame   | out | valid/ready   | frame_byte[7:0], frame_first, frame_last, length_error
//   cfg     | in  | cfg_we        | cfg_wdata[19:0] = max_frame_bytes
//
// one byte per cycle sustained while the frame channel is ready and no magic burst is going out;
// a byte goes from the input register to the result register, and frame valid rises when it
// is loaded there; a magic word match holds the result register while the eight magic
// bytes go out; the next byte waits in the input register until the last of them transfers
// a stalled frame channel fills the input register, then rx ready drops
// reset clears history, frame state and sets max_frame_bytes to 65536
module magic_word_frame_extractor
	import mwfe_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	byte_if.sink                   rx,
	frame_if.source                frame,
	input  logic                   cfg_we,
	input  logic [MAXCFG_BITS-1:0] cfg_wdata
);

	res_t res;
	logic free;

	mwfe_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rx.valid),
		.in_byte   (rx.rx_byte),
		.in_ready  (rx.ready),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_free  (free),
		.res       (res)
	);

	mwfe_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.free      (free),
		.out_valid (frame.valid),
		.out_ready (frame.ready),
		.out_byte  (frame.frame_byte),
		.out_first (frame.frame_first),
		.out_last  (frame.frame_last),
		.out_err   (frame.length_error)
	);

endmodule

// ===== src/mwfe_parse.sv =====
// input register, magic word hunt, length tracking and last/error decision
module mwfe_parse
	import mwfe_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic [7:0]             in_byte,
	output logic                   in_ready,
	input  logic                   cfg_we,
	input  logic [MAXCFG_BITS-1:0] cfg_wdata,
	input  logic                   out_free,
	output res_t                   res
);

	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic [MAXCFG_BITS-1:0] max_q;
	logic [63:0]            history_q;
	logic                   in_frame_q;
	logic [COUNT_BITS-1:0]  pos_q;
	logic [LEN_BITS-1:0]    len_q;

	logic [63:0]            hist_next;
	logic                   match;
	logic                   produce;
	logic                   advance;
	logic [LEN_BITS-1:0]    len_next;
	logic [MAXCFG_BITS-1:0] max_eff;
	logic                   last;
	logic                   err;

	assign hist_next = {history_q[55:0], byte_s1};
	assign match = (hist_next == MAGIC_WORD);
	assign produce = in_frame_q || match;
	assign advance = valid_s1 && (!produce || out_free);
	assign in_ready = !valid_s1 || advance;
	assign max_eff = (max_q < MIN_FRAME) ? MIN_FRAME : max_q;

	// frame bytes 12..15 carry the little-endian length
	always_comb begin
		len_next = len_q;
		if (pos_q[COUNT_BITS-1:2] == (COUNT_BITS-2)'(3)) begin
			case (pos_q[1:0])
				2'd0: len_next[7:0] = byte_s1;
				2'd1: len_next[15:8] = byte_s1;
				2'd2: len_next[23:16] = byte_s1;
				2'd3: len_next[31:24] = byte_s1;
				default: len_next = len_q;
			endcase
		end
	end

	always_comb begin
		last = 1'b0;
		err = 1'b0;
		if (pos_q >= POS_LEN_LAST) begin
			if (pos_q == POS_LEN_LAST && len_next < LEN_BITS'(MIN_FRAME)) begin
				last = 1'b1;
				err = 1'b1;
			end else if (len_next > LEN_BITS'(max_eff)) begin
				if (pos_q >= max_eff - MAXCFG_BITS'(1)) begin
					last = 1'b1;
					err = 1'b1;
				end
			end else if (LEN_BITS'(pos_q) >= len_next - LEN_BITS'(1)) begin
				last = 1'b1;
			end
		end
	end

	always_comb begin
		res.valid = valid_s1 && produce;
		res.burst = !in_frame_q;
		res.data = byte_s1;
		res.last = in_frame_q && last;
		res.err = in_frame_q && err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_RESET;
		end else if (cfg_we) begin
			max_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			history_q <= '0;
			in_frame_q <= 1'b0;
			pos_q <= '0;
			len_q <= '0;
		end else if (advance) begin
			if (!in_frame_q) begin
				if (match) begin
					history_q <= '0;
					in_frame_q <= 1'b1;
					pos_q <= POS_AFTER_MAGIC;
					len_q <= '0;
				end else begin
					history_q <= hist_next;
				end
			end else if (last) begin
				history_q <= '0;
				in_frame_q <= 1'b0;
				pos_q <= '0;
				len_q <= '0;
			end else begin
				pos_q <= pos_q + COUNT_BITS'(1);
				len_q <= len_next;
			end
		end
	end

endmodule

// ===== src/mwfe_out.sv =====
// result register with the eight byte magic word burst
module mwfe_out
	import mwfe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  res_t       res,
	output logic       free,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_first,
	output logic       out_last,
	output logic       out_err
);

	logic       valid_q;
	logic       burst_q;
	logic [2:0] idx_q;
	logic [7:0] data_q;
	logic       first_q;
	logic       last_q;
	logic       err_q;
	logic       xfer;
	logic       burst_more;

	assign xfer = valid_q && out_ready;
	assign burst_more = burst_q && (idx_q != 3'd7);
	assign free = !valid_q || (out_ready && !burst_more);

	assign out_valid = valid_q;
	assign out_byte = data_q;
	assign out_first = first_q;
	assign out_last = last_q;
	assign out_err = err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			burst_q <= 1'b0;
			idx_q <= '0;
		end else if (xfer && burst_more) begin
			idx_q <= idx_q + 3'd1;
		end else if (free) begin
			valid_q <= res.valid;
			burst_q <= res.valid && res.burst;
			idx_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (xfer && burst_more) begin
			data_q <= magic_byte(idx_q + 3'd1);
			first_q <= 1'b0;
		end else if (free && res.valid) begin
			data_q <= res.burst ? magic_byte(3'd0) : res.data;
			first_q <= res.burst;
			last_q <= res.last;
			err_q <= res.err;
		end
	end

`ifndef SYNTHESIS
	a_idx_only_in_burst: assert property (@(posedge clk) disable iff (!arst_n)
		!burst_q |-> idx_q == 3'd0)
		else $error("magic index moved outside a burst");

	a_first_at_burst_head: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && first_q |-> burst_q && idx_q == 3'd0)
		else $error("frame start flag off the first magic byte");

	a_burst_data: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && burst_q |-> data_q == magic_byte(idx_q) && !last_q && !err_q)
		else $error("magic burst byte wrong");

	a_burst_steps: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && burst_more |=> valid_q && burst_q && idx_q == $past(idx_q) + 3'd1)
		else $error("magic burst skipped a byte");
`endif

endmodule
